@@ rtl/core/slpe_pkg.sv @@
// Package with the shared types and constants of the status LED pattern engine.
package slpe_pkg;

   // Default tick length in microseconds.
   localparam int unsigned TICK_US_DEFAULT = 625;
   localparam int unsigned MS_US           = 1000;

   // Phase counter periods in ticks, and their widths.
   localparam int unsigned FLASH_W      = 8;
   localparam int unsigned ALT_W        = 10;
   localparam int unsigned BURST_W      = 13;
   localparam int unsigned FLASH_TICKS  = 240;
   localparam int unsigned ALT_TICKS    = 640;
   localparam int unsigned BURST_TICKS  = 4800;

   // Restart counter width and its saturation value.
   localparam int unsigned RESTART_W = 24;
   localparam logic [RESTART_W-1:0] RESTART_MAX = {RESTART_W{1'b1}};

   // Configuration port.
   localparam int unsigned CSR_INDEX_W     = 4;
   localparam int unsigned CSR_DATA_W      = 16;
   localparam int unsigned LIMIT_W         = CSR_DATA_W + 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_BLINK_OFF_MS   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_LOCK_LED_ENABLE = 4'd1;
   localparam logic [CSR_DATA_W-1:0]  BLUE_BLINK_OFF_RESET    = 16'd10000;

   // Stream payload widths.
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 8;

   // Link states.
   localparam logic [2:0] LINK_OFF          = 3'd0;
   localparam logic [2:0] LINK_RECONNECTING = 3'd1;
   localparam logic [2:0] LINK_PAIRING      = 3'd2;
   localparam logic [2:0] LINK_SLOT1        = 3'd3;
   localparam logic [2:0] LINK_SLOT4        = 3'd6;

   // Battery warning thresholds in percent.
   localparam logic [6:0] BATT_THREE_BLINKS = 7'd10;
   localparam logic [6:0] BATT_TWO_BLINKS   = 7'd15;
   localparam logic [6:0] BATT_ONE_BLINK    = 7'd20;

   // LED modes.
   typedef logic [3:0] mode_type;
   localparam mode_type MODE_OFF    = 4'd0;
   localparam mode_type MODE_ON     = 4'd1;
   localparam mode_type MODE_FLASH  = 4'd2;
   localparam mode_type MODE_ALT_A  = 4'd3;
   localparam mode_type MODE_ALT_B  = 4'd4;
   localparam mode_type MODE_BLINK1 = 4'd5;
   localparam mode_type MODE_BLINK2 = 4'd6;
   localparam mode_type MODE_BLINK3 = 4'd7;
   localparam mode_type MODE_BLINK4 = 4'd8;

   // Input transaction fields, last field first so the lowest bits map to sleeping.
   typedef struct packed {
      logic       link_restart;
      logic [2:0] link_state;
      logic       usb_mode;
      logic [6:0] battery_percent;
      logic       num_lock_on;
      logic       caps_lock_on;
      logic       keyboard_init;
      logic       sleeping;
   } req_fields_type;

endpackage

@@ rtl/core/status_led_pattern_engine.sv @@
// Top level of the status LED pattern engine: tick pipeline, phase counters and LED mode logic.
//
// Each request transaction is one system tick of TICK_US microseconds carrying the status
// inputs; each one yields exactly one response transaction with the red, green and blue LED
// bits. The block accepts one transaction per clock cycle while responses are taken and
// passes each through the input register, then the mode logic and counter update into the
// output register. Throughput is set by that two-register pipeline; while a response waits
// to be taken, the input register can still take one more transaction, and after that the
// request side stalls. Millisecond thresholds are turned into
// tick counts when the design is elaborated, so no division happens at run time; the blue
// blink window compares ticks times TICK_US against the written limit times 1000.
module status_led_pattern_engine #(
   parameter int unsigned TICK_US = slpe_pkg::TICK_US_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream. tdata from bit 0: sleeping, keyboard_init, caps_lock_on, num_lock_on,
   // battery_percent[6:0], usb_mode, link_state[2:0], link_restart.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [slpe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Response stream. tdata from bit 0: red_on, green_on, blue_on, then zero fill.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [slpe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slpe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [slpe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import slpe_pkg::*;

   // Millisecond thresholds as tick counts: ms < c holds exactly when ticks < ceil(c*1000/T).
   localparam int unsigned FLASH_ON_T = (50 * MS_US + TICK_US - 1) / TICK_US;
   localparam int unsigned ALT_HALF_T = (200 * MS_US + TICK_US - 1) / TICK_US;
   localparam int unsigned B0_END_T   = (50 * MS_US + TICK_US - 1) / TICK_US;
   localparam int unsigned B1_BEG_T   = (200 * MS_US + TICK_US - 1) / TICK_US;
   localparam int unsigned B1_END_T   = (250 * MS_US + TICK_US - 1) / TICK_US;
   localparam int unsigned B2_BEG_T   = (400 * MS_US + TICK_US - 1) / TICK_US;
   localparam int unsigned B2_END_T   = (450 * MS_US + TICK_US - 1) / TICK_US;
   localparam int unsigned B3_BEG_T   = (600 * MS_US + TICK_US - 1) / TICK_US;
   localparam int unsigned B3_END_T   = (650 * MS_US + TICK_US - 1) / TICK_US;

   // Width of ticks times TICK_US and of the window compare.
   localparam int unsigned PROD_W = RESTART_W + $clog2(TICK_US + 1);
   localparam int unsigned CMP_W  = (PROD_W > LIMIT_W) ? PROD_W : LIMIT_W;

   // Configuration registers; the blink window is kept in microseconds.
   logic [LIMIT_W-1:0] blue_limit_ff, blue_limit_in;
   logic               num_enable_ff, num_enable_in;

   // Pipeline registers.
   logic                  s1_valid_ff, s1_valid_in;
   req_fields_type        s1_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_leds_ff, rsp_leds_in;

   // Pattern state.
   logic [FLASH_W-1:0]   phase_flash_ff, phase_flash_in;
   logic [ALT_W-1:0]     phase_alt_ff, phase_alt_in;
   logic [BURST_W-1:0]   phase_burst_ff, phase_burst_in;
   logic [RESTART_W-1:0] ticks_ff, ticks_in;
   logic                 was_sleeping_ff, was_sleeping_in;

   // Handshake and datapath signals.
   logic                  out_free;
   logic                  s1_advance;
   logic                  req_take;
   logic [RESTART_W-1:0]  ticks_eff;
   logic [CMP_W-1:0]      ticks_us;
   logic                  in_window;
   logic                  flash_lit;
   logic                  alt_a_lit;
   logic                  blink_lit [4];
   mode_type              red_mode;
   mode_type              green_mode;
   mode_type              blue_mode;

   // Pipeline handshake: the input register drains whenever the output slot is free.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_tready);

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      blue_limit_in = blue_limit_ff;
      num_enable_in = num_enable_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BLUE_BLINK_OFF_MS) begin
            blue_limit_in = LIMIT_W'(csr_wdata) * LIMIT_W'(MS_US);
         end else if (csr_index == CSR_NUM_LOCK_LED_ENABLE) begin
            num_enable_in = csr_wdata[0];
         end
      end
   end

   // The restart counter is cleared on wake-up or on a link restart before it is used.
   always_comb begin
      if ((was_sleeping_ff && !s1_data_ff.sleeping) || s1_data_ff.link_restart) begin
         ticks_eff = '0;
      end else begin
         ticks_eff = ticks_ff;
      end
   end

   assign ticks_us  = CMP_W'(PROD_W'(ticks_eff) * PROD_W'(TICK_US));
   assign in_window = ticks_us < CMP_W'(blue_limit_ff);

   // Pattern phases compared against elaboration-time tick thresholds.
   always_comb begin
      flash_lit    = 32'(phase_flash_ff) < FLASH_ON_T;
      alt_a_lit    = 32'(phase_alt_ff) < ALT_HALF_T;
      blink_lit[0] = 32'(phase_burst_ff) < B0_END_T;
      blink_lit[1] = (32'(phase_burst_ff) >= B1_BEG_T) && (32'(phase_burst_ff) < B1_END_T);
      blink_lit[2] = (32'(phase_burst_ff) >= B2_BEG_T) && (32'(phase_burst_ff) < B2_END_T);
      blink_lit[3] = (32'(phase_burst_ff) >= B3_BEG_T) && (32'(phase_burst_ff) < B3_END_T);
   end

   // Mode selection for each LED.
   always_comb begin
      red_mode   = MODE_OFF;
      green_mode = MODE_OFF;
      blue_mode  = MODE_OFF;
      if (!s1_data_ff.sleeping) begin
         if (s1_data_ff.keyboard_init) begin
            red_mode   = MODE_ON;
            green_mode = MODE_ON;
            blue_mode  = MODE_ON;
         end else begin
            if (s1_data_ff.caps_lock_on) begin
               green_mode = MODE_ON;
            end
            priority if (num_enable_ff && s1_data_ff.num_lock_on) begin
               red_mode = MODE_ON;
            end else if (s1_data_ff.battery_percent < BATT_THREE_BLINKS) begin
               red_mode = MODE_BLINK3;
            end else if (s1_data_ff.battery_percent < BATT_TWO_BLINKS) begin
               red_mode = MODE_BLINK2;
            end else if (s1_data_ff.battery_percent < BATT_ONE_BLINK) begin
               red_mode = MODE_BLINK1;
            end else begin
               red_mode = MODE_OFF;
            end
            // Link state drives blue; pairing also takes over red.
            priority if (s1_data_ff.usb_mode || s1_data_ff.link_state == LINK_OFF) begin
               blue_mode = MODE_OFF;
            end else if (s1_data_ff.link_state == LINK_RECONNECTING) begin
               blue_mode = MODE_FLASH;
            end else if (s1_data_ff.link_state == LINK_PAIRING) begin
               blue_mode = MODE_ALT_A;
               red_mode  = MODE_ALT_B;
            end else if (s1_data_ff.link_state >= LINK_SLOT1 &&
                         s1_data_ff.link_state <= LINK_SLOT4 && in_window) begin
               blue_mode = MODE_BLINK1 + mode_type'(s1_data_ff.link_state - LINK_SLOT1);
            end else begin
               blue_mode = MODE_OFF;
            end
         end
      end
   end

   // Turns a mode into the lit state for the current phases.
   function automatic logic mode_lit(input mode_type m, input logic flash, input logic alt_a,
                                     input logic b0, input logic b1, input logic b2,
                                     input logic b3);
      logic lit;
      unique case (m)
         MODE_ON:     lit = 1'b1;
         MODE_FLASH:  lit = flash;
         MODE_ALT_A:  lit = alt_a;
         MODE_ALT_B:  lit = !alt_a;
         MODE_BLINK1: lit = b0;
         MODE_BLINK2: lit = b0 || b1;
         MODE_BLINK3: lit = b0 || b1 || b2;
         MODE_BLINK4: lit = b0 || b1 || b2 || b3;
         default:     lit = 1'b0;
      endcase
      return lit;
   endfunction

   // Response bits and counter update for the transaction leaving the input register.
   always_comb begin
      rsp_leds_in     = rsp_leds_ff;
      phase_flash_in  = phase_flash_ff;
      phase_alt_in    = phase_alt_ff;
      phase_burst_in  = phase_burst_ff;
      ticks_in        = ticks_ff;
      was_sleeping_in = was_sleeping_ff;
      if (s1_advance) begin
         rsp_leds_in[0] = mode_lit(red_mode, flash_lit, alt_a_lit, blink_lit[0], blink_lit[1],
                                   blink_lit[2], blink_lit[3]);
         rsp_leds_in[1] = mode_lit(green_mode, flash_lit, alt_a_lit, blink_lit[0],
                                   blink_lit[1], blink_lit[2], blink_lit[3]);
         rsp_leds_in[2] = mode_lit(blue_mode, flash_lit, alt_a_lit, blink_lit[0],
                                   blink_lit[1], blink_lit[2], blink_lit[3]);
         phase_flash_in = (phase_flash_ff == FLASH_W'(FLASH_TICKS - 1)) ? '0
                                                                        : phase_flash_ff + 1'b1;
         phase_alt_in   = (phase_alt_ff == ALT_W'(ALT_TICKS - 1)) ? '0 : phase_alt_ff + 1'b1;
         phase_burst_in = (phase_burst_ff == BURST_W'(BURST_TICKS - 1)) ? '0
                                                                        : phase_burst_ff + 1'b1;
         ticks_in        = (ticks_eff == RESTART_MAX) ? ticks_eff : ticks_eff + 1'b1;
         was_sleeping_in = s1_data_ff.sleeping;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         blue_limit_ff   <= LIMIT_W'(BLUE_BLINK_OFF_RESET) * LIMIT_W'(MS_US);
         num_enable_ff   <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_flash_ff  <= '0;
         phase_alt_ff    <= '0;
         phase_burst_ff  <= '0;
         ticks_ff        <= '0;
         was_sleeping_ff <= 1'b0;
      end else begin
         blue_limit_ff   <= blue_limit_in;
         num_enable_ff   <= num_enable_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         phase_flash_ff  <= phase_flash_in;
         phase_alt_ff    <= phase_alt_in;
         phase_burst_ff  <= phase_burst_in;
         ticks_ff        <= ticks_in;
         was_sleeping_ff <= was_sleeping_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_fields_type'(req_tdata);
      end
      rsp_leds_ff <= rsp_leds_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 3){1'b0}}, rsp_leds_ff};

   // A link restart leaves the restart counter at one after its tick.
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_data_ff.link_restart) |=> (ticks_ff == RESTART_W'(1)))
      else $error("restart counter not restarted by link restart");

   // A sleeping tick produces a response with all LEDs off.
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_data_ff.sleeping) |=> (rsp_leds_ff == 3'b000))
      else $error("LED lit during sleep");

   // The flash phase never leaves its period.
   assert property (@(posedge clock) disable iff (reset)
      32'(phase_flash_ff) < FLASH_TICKS)
      else $error("flash phase out of range");

   // An empty input register always takes a new transaction.
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stalled while input register empty");

endmodule
